// File: rtl/core/wbft_pkg.sv
// Shared types and constants for the write budget flush trigger unit.
package wbft_pkg;

  // Operation codes of a request.
  localparam logic [2:0] FUNC_RESERVE    = 3'd0;
  localparam logic [2:0] FUNC_FREE       = 3'd1;
  localparam logic [2:0] FUNC_REGISTER   = 3'd2;
  localparam logic [2:0] FUNC_UNREGISTER = 3'd3;
  localparam logic [2:0] FUNC_SHUTDOWN   = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_ROOM   = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_SHUT_DOWN = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  // Configuration register byte addresses.
  localparam logic [4:0] ADDR_LIMIT  = 5'd0;
  localparam logic [4:0] ADDR_WINDOW = 5'd8;
  localparam logic [4:0] ADDR_FTL    = 5'd16;

  // Register reset values.
  localparam logic [39:0] LIMIT_RST  = 40'd67108864;
  localparam logic [47:0] WINDOW_RST = 48'd1000000000;
  localparam logic [47:0] FTL_RST    = 48'd1000000000;

  // Nanoseconds per second; 1 MiB/s is a shift by RATE_SHIFT.
  localparam logic [47:0] NS_PER_S   = 48'd1000000000;
  localparam int          RATE_SHIFT = 20;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 48;
  localparam int PROD_W = 96;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  owner_id;
    logic [39:0] amount;
    logic [47:0] now_ns;
  } wbft_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [39:0] usage;
    logic        flush_request;
    logic [7:0]  flush_owner;
    logic [4:0]  candidate_count;
  } wbft_rsp_t;

endpackage

// File: rtl/core/wbft_ram.sv
// Generic simple dual-port RAM with registered read data.
module wbft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/wbft_mul.sv
// Shift-add multiplier that retires one multiplier bit per cycle.
module wbft_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wbft_pkg::MUL_W-1:0] a,
  input  logic [wbft_pkg::MUL_W-1:0] b,
  output logic                       done,
  output logic [wbft_pkg::PROD_W-1:0] prod
);
  import wbft_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MUL_W-1:0]  a_r, a_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [MUL_W:0]    sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift right.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    sum      = {1'b0, acc_r[PROD_W-1:MUL_W]} + (acc_r[0] ? {1'b0, a_r} : '0);
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      acc_nxt  = {{MUL_W{1'b0}}, b};
    end else if (busy_r) begin
      acc_nxt = {sum, acc_r[MUL_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: rtl/core/write_budget_flush_trigger_unit.sv
// Top level of the write budget flush trigger unit.
//
// A request is taken when start is high and busy is low; busy stays high
// until its result has been produced. Each request yields exactly one result,
// shown on out_rsp for a single cycle with out_valid high; the receiver
// cannot stall it. Registers are written through the APB-style port; the
// user must write them only while the unit is idle: the block does not enforce it.
// Request flow: free, shutdown, unknown codes and a refused reserve go
// straight to the result; a granted reserve then checks history samples
// for pruning, oldest first; a register scans the valid bits one slot a
// cycle, then the flush test runs up to three passes of the shared
// shift-add multiplier, and a chosen flush walks the whole candidate RAM,
// one slot after another; an unregister takes that same walk. The serial
// multiplier and the one-read-per-cycle candidate and history RAMs set
// the length of a request.
// After reset the budget is empty, the history and candidate table are empty
// and the registers hold their reset values; no clearing pass is needed.
module write_budget_flush_trigger_unit #(
  parameter int HISTORY_DEPTH = 16,
  parameter int CAND_DEPTH    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wbft_pkg::wbft_req_t in_req,
  output logic                out_valid,
  output wbft_pkg::wbft_rsp_t out_rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import wbft_pkg::*;

  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW  = (CAND_DEPTH > 1) ? $clog2(CAND_DEPTH) : 1;
  localparam int CCW = $clog2(CAND_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_PR_RD, S_PR_CK, S_REG_SCAN, S_FL_CHK, S_FL_RD1, S_FL_RD2,
    S_FL_CAP, S_M1_GO, S_M1_WT, S_M2_GO, S_M2_WT, S_M3_GO, S_M3_WT,
    S_WALK_RD, S_WALK_CK, S_WALK_END, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  wbft_req_t          req_r, req_nxt;
  logic [39:0]        limit_r, limit_nxt;
  logic [47:0]        window_r, window_nxt;
  logic [47:0]        ftl_r, ftl_nxt;
  logic [39:0]        total_r, total_nxt;
  logic               stopped_r, stopped_nxt;
  logic [HW-1:0]      s_head_r, s_head_nxt;
  logic [HCW-1:0]     s_count_r, s_count_nxt;
  logic [CAND_DEPTH-1:0] valid_r, valid_nxt;
  logic [CCW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               walk_flush_r, walk_flush_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      pick_r, pick_nxt;
  logic [47:0]        pick_time_r, pick_time_nxt;
  logic [7:0]         pick_owner_r, pick_owner_nxt;
  logic [47:0]        first_t_r, first_t_nxt;
  logic [39:0]        first_v_r, first_v_nxt;
  logic [47:0]        dur_r, dur_nxt;
  logic [39:0]        added_r, added_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               flush_r, flush_nxt;
  logic [7:0]         fowner_r, fowner_nxt;
  logic               out_valid_r, out_valid_nxt;
  wbft_rsp_t          out_rsp_r, out_rsp_nxt;

  // History RAM: {time, total}; candidate RAM: {owner, bytes, time}.
  logic               s_we;
  logic [HW-1:0]      s_waddr, s_raddr;
  logic [87:0]        s_wdata, s_rdata;
  logic               c_we;
  logic [CW-1:0]      c_raddr;
  logic [95:0]        c_wdata, c_rdata;

  logic               mul_start, mul_done;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_prod;

  logic               cfg_wr;
  logic [40:0]        rsv_sum;
  logic [41:0]        lim3;
  logic [39:0]        remain;
  logic [HW:0]        hsum, hslot, hlast;
  logic [HW-1:0]      head_inc;
  logic [47:0]        t_rd;
  logic               cand_hit;

  wbft_ram #(.WIDTH(88), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  wbft_ram #(.WIDTH(96), .DEPTH(CAND_DEPTH)) u_cand_ram (
    .clk(clk), .we(c_we), .waddr(idx_r), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  wbft_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  // Shared arithmetic on the held state.
  always_comb begin
    rsv_sum  = {1'b0, total_r} + {1'b0, req_r.amount};
    lim3     = {2'b0, limit_r} + {1'b0, limit_r, 1'b0};
    remain   = (limit_r > total_r) ? (limit_r - total_r) : '0;
    head_inc = (s_head_r == HW'(HISTORY_DEPTH - 1)) ? '0 : s_head_r + 1'b1;
    hsum     = {1'b0, s_head_r} + (HW+1)'(s_count_r);
    hslot    = (hsum >= (HW+1)'(HISTORY_DEPTH)) ? hsum - (HW+1)'(HISTORY_DEPTH) : hsum;
    hlast    = hsum - 1'b1;
    if (hlast >= (HW+1)'(HISTORY_DEPTH)) begin
      hlast = hlast - (HW+1)'(HISTORY_DEPTH);
    end
    t_rd     = s_rdata[87:40];
    cand_hit = valid_r[idx_r] &&
               (walk_flush_r ||
                (c_rdata[95:88] == req_r.owner_id && c_rdata[87:48] == req_r.amount)) &&
               (!found_r || c_rdata[47:0] < pick_time_r);
  end

  // Multiplier operand selection for the three products of the flush test.
  always_comb begin
    mul_a = ftl_r;
    mul_b = {8'b0, added_r};
    unique case (state_r)
      S_M1_GO: begin
        mul_a = {8'b0, added_r};
        mul_b = NS_PER_S;
      end
      S_M2_GO: begin
        mul_a = {8'b0, remain};
        mul_b = dur_r;
      end
      default: begin
        mul_a = ftl_r;
        mul_b = {8'b0, added_r};
      end
    endcase
  end

  assign mul_start = (state_r == S_M1_GO) || (state_r == S_M2_GO) || (state_r == S_M3_GO);
  assign cfg_wr    = psel && penable && pwrite;

  // Configuration read data.
  always_comb begin
    unique case (paddr)
      ADDR_LIMIT:  prdata = {24'b0, limit_r};
      ADDR_WINDOW: prdata = {16'b0, window_r};
      ADDR_FTL:    prdata = {16'b0, ftl_r};
      default:     prdata = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    limit_nxt      = limit_r;
    window_nxt     = window_r;
    ftl_nxt        = ftl_r;
    total_nxt      = total_r;
    stopped_nxt    = stopped_r;
    s_head_nxt     = s_head_r;
    s_count_nxt    = s_count_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    walk_flush_nxt = walk_flush_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    pick_time_nxt  = pick_time_r;
    pick_owner_nxt = pick_owner_r;
    first_t_nxt    = first_t_r;
    first_v_nxt    = first_v_r;
    dur_nxt        = dur_r;
    added_nxt      = added_r;
    prod_nxt       = prod_r;
    status_nxt     = status_r;
    flush_nxt      = flush_r;
    fowner_nxt     = fowner_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    s_we           = 1'b0;
    s_waddr        = hslot[HW-1:0];
    s_wdata        = {req_r.now_ns, rsv_sum[39:0]};
    s_raddr        = s_head_r;
    c_we           = 1'b0;
    c_wdata        = {req_r.owner_id, req_r.amount, req_r.now_ns};
    c_raddr        = idx_r;

    // The user must let register writes arrive only while idle; the sequencer does not enforce it.
    if (cfg_wr) begin
      unique case (paddr)
        ADDR_LIMIT:  limit_nxt  = pwdata[39:0];
        ADDR_WINDOW: window_nxt = pwdata[47:0];
        ADDR_FTL:    ftl_nxt    = pwdata[47:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          status_nxt = STAT_OK;
          flush_nxt  = 1'b0;
          fowner_nxt = '0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = S_DONE;
        unique case (req_r.func)
          FUNC_RESERVE: begin
            if (stopped_r) begin
              status_nxt = STAT_SHUT_DOWN;
            end else if (rsv_sum > {1'b0, limit_r}) begin
              status_nxt = STAT_NO_ROOM;
            end else begin
              // Append the sample, overwriting the oldest when the ring is full.
              total_nxt = rsv_sum[39:0];
              s_we      = 1'b1;
              if (s_count_r < HCW'(HISTORY_DEPTH)) begin
                s_count_nxt = s_count_r + 1'b1;
              end else begin
                s_waddr    = s_head_r;
                s_head_nxt = head_inc;
              end
              state_nxt = S_PR_RD;
            end
          end
          FUNC_FREE: begin
            total_nxt = (total_r > req_r.amount) ? total_r - req_r.amount : '0;
          end
          FUNC_REGISTER: begin
            state_nxt = S_REG_SCAN;
          end
          FUNC_UNREGISTER: begin
            walk_flush_nxt = 1'b0;
            state_nxt      = S_WALK_RD;
          end
          FUNC_SHUTDOWN: begin
            stopped_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      // Prune samples older than the window, oldest first.
      S_PR_RD: begin
        state_nxt = S_PR_CK;
      end

      S_PR_CK: begin
        state_nxt = S_DONE;
        if (req_r.now_ns >= t_rd && (req_r.now_ns - t_rd) > window_r) begin
          s_head_nxt  = head_inc;
          s_count_nxt = s_count_r - 1'b1;
          if (s_count_r != HCW'(1)) begin
            state_nxt = S_PR_RD;
          end
        end
      end

      // Store the candidate in the first free slot.
      S_REG_SCAN: begin
        if (!valid_r[idx_r]) begin
          c_we              = 1'b1;
          valid_nxt[idx_r]  = 1'b1;
          cnt_nxt           = cnt_r + 1'b1;
          state_nxt         = S_FL_CHK;
        end else if (idx_r == CW'(CAND_DEPTH - 1)) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Threshold test, then the rate test needs two samples.
      S_FL_CHK: begin
        idx_nxt        = '0;
        found_nxt      = 1'b0;
        walk_flush_nxt = 1'b1;
        if (total_r > lim3[41:2]) begin
          state_nxt = S_WALK_RD;
        end else if (s_count_r < HCW'(2)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FL_RD1;
        end
      end

      S_FL_RD1: begin
        state_nxt = S_FL_RD2;
      end

      S_FL_RD2: begin
        s_raddr     = hlast[HW-1:0];
        first_t_nxt = s_rdata[87:40];
        first_v_nxt = s_rdata[39:0];
        state_nxt   = S_FL_CAP;
      end

      S_FL_CAP: begin
        dur_nxt   = t_rd - first_t_r;
        added_nxt = (s_rdata[39:0] > first_v_r) ? s_rdata[39:0] - first_v_r : '0;
        state_nxt = (t_rd > first_t_r) ? S_M1_GO : S_DONE;
      end

      // Fill rate above 1 MiB/s: added * 1e9 > dur * 2^20.
      S_M1_GO: state_nxt = S_M1_WT;
      S_M1_WT: begin
        if (mul_done) begin
          state_nxt = (mul_prod > PROD_W'({dur_r, {RATE_SHIFT{1'b0}}})) ? S_M2_GO : S_DONE;
        end
      end

      // Time to full below the limit: full_time_limit * added > remain * dur.
      S_M2_GO: state_nxt = S_M2_WT;
      S_M2_WT: begin
        if (mul_done) begin
          prod_nxt  = mul_prod;
          state_nxt = S_M3_GO;
        end
      end

      S_M3_GO: state_nxt = S_M3_WT;
      S_M3_WT: begin
        if (mul_done) begin
          state_nxt = (mul_prod > prod_r) ? S_WALK_RD : S_DONE;
        end
      end

      // Walk the candidates for the oldest match, lowest slot on ties.
      S_WALK_RD: begin
        state_nxt = S_WALK_CK;
      end

      S_WALK_CK: begin
        if (cand_hit) begin
          found_nxt      = 1'b1;
          pick_nxt       = idx_r;
          pick_time_nxt  = c_rdata[47:0];
          pick_owner_nxt = c_rdata[95:88];
        end
        if (idx_r == CW'(CAND_DEPTH - 1)) begin
          state_nxt = S_WALK_END;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WALK_RD;
        end
      end

      S_WALK_END: begin
        state_nxt = S_DONE;
        if (found_r) begin
          valid_nxt[pick_r] = 1'b0;
          cnt_nxt           = cnt_r - 1'b1;
          if (walk_flush_r) begin
            flush_nxt  = 1'b1;
            fowner_nxt = pick_owner_r;
          end
        end else begin
          status_nxt = STAT_NOT_FOUND;
        end
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{status: status_r, usage: total_r, flush_request: flush_r,
                          flush_owner: fowner_r, candidate_count: 5'(cnt_r)};
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    pick_time_r  <= pick_time_nxt;
    pick_owner_r <= pick_owner_nxt;
    first_t_r    <= first_t_nxt;
    first_v_r    <= first_v_nxt;
    dur_r        <= dur_nxt;
    added_r      <= added_nxt;
    prod_r       <= prod_nxt;
    status_r     <= status_nxt;
    flush_r      <= flush_nxt;
    fowner_r     <= fowner_nxt;
    walk_flush_r <= walk_flush_nxt;
    found_r      <= found_nxt;
    out_rsp_r    <= out_rsp_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RST;
      window_r    <= WINDOW_RST;
      ftl_r       <= FTL_RST;
      total_r     <= '0;
      stopped_r   <= 1'b0;
      s_head_r    <= '0;
      s_count_r   <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      window_r    <= window_nxt;
      ftl_r       <= ftl_nxt;
      total_r     <= total_nxt;
      stopped_r   <= stopped_nxt;
      s_head_r    <= s_head_nxt;
      s_count_r   <= s_count_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign pready    = 1'b1;

endmodule

// File: test/write_budget_flush_trigger_unit_tb.sv
// Self-checking testbench for the write budget flush trigger unit.
module write_budget_flush_trigger_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wbft_pkg::*;

  localparam int HIST_N = 16;
  localparam int CAND_N = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 250;
  localparam int PHASE_ITEMS = 270;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  wbft_req_t in_req = '0;
  logic out_valid;
  wbft_rsp_t out_rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  write_budget_flush_trigger_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the unit's configuration and state.
  logic [39:0] bud_limit = LIMIT_RST;
  logic [47:0] prune_age = WINDOW_RST;
  logic [47:0] fill_deadline = FTL_RST;
  logic [39:0] bud_total = '0;
  bit          halted = 1'b0;
  logic [47:0] smp_time [HIST_N];
  logic [39:0] smp_total [HIST_N];
  int          smp_cnt = 0;
  int          smp_head = 0;
  logic [7:0]  cd_owner [CAND_N];
  logic [39:0] cd_bytes [CAND_N];
  logic [47:0] cd_time [CAND_N];
  bit          cd_valid [CAND_N];

  wbft_req_t pending_reqs[$];
  wbft_rsp_t expected_rsps[$];
  int fails = 0;
  int gap = 0;
  bit idling_on = 1'b1;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < CAND_N; i++) cd_valid[i] = 1'b0;
  end

  // Append a usage sample and drop samples older than the window.
  function automatic void log_sample(logic [47:0] now);
    int slot;
    if (smp_cnt < HIST_N) begin
      slot = (smp_head + smp_cnt) % HIST_N;
      smp_cnt++;
    end else begin
      slot = smp_head;
      smp_head = (smp_head + 1) % HIST_N;
    end
    smp_time[slot] = now;
    smp_total[slot] = bud_total;
    while (smp_cnt > 0) begin
      if (now >= smp_time[smp_head] && now - smp_time[smp_head] > prune_age) begin
        smp_head = (smp_head + 1) % HIST_N;
        smp_cnt--;
      end else begin
        break;
      end
    end
  endfunction

  // Flush decision: high watermark, or fast fill with a short time to full.
  function automatic bit flush_due();
    logic [127:0] lhs, rhs;
    logic [47:0] dur;
    logic [39:0] added, remain;
    int last;
    if (64'(bud_total) > (64'(bud_limit) * 3) / 4) return 1'b1;
    if (smp_cnt < 2) return 1'b0;
    last = (smp_head + smp_cnt - 1) % HIST_N;
    if (smp_time[last] <= smp_time[smp_head]) return 1'b0;
    dur = smp_time[last] - smp_time[smp_head];
    added = smp_total[last] > smp_total[smp_head] ? smp_total[last] - smp_total[smp_head] : '0;
    lhs = 128'(added) * 128'(NS_PER_S);
    rhs = 128'(dur) << RATE_SHIFT;
    if (!(lhs > rhs)) return 1'b0;
    remain = bud_limit > bud_total ? bud_limit - bud_total : '0;
    lhs = 128'(remain) * 128'(dur);
    rhs = 128'(fill_deadline) * 128'(added);
    return rhs > lhs;
  endfunction

  // Compute the result of one request and advance the shadow state.
  function automatic wbft_rsp_t budget_step(wbft_req_t r);
    wbft_rsp_t rsp;
    int pick;
    bit found;
    rsp = '0;
    rsp.status = STAT_OK;
    case (r.func)
      FUNC_RESERVE: begin
        if (halted) rsp.status = STAT_SHUT_DOWN;
        else if (41'(bud_total) + 41'(r.amount) > 41'(bud_limit)) rsp.status = STAT_NO_ROOM;
        else begin
          bud_total = bud_total + r.amount;
          log_sample(r.now_ns);
        end
      end
      FUNC_FREE: bud_total = bud_total > r.amount ? bud_total - r.amount : '0;
      FUNC_REGISTER: begin
        found = 1'b0;
        for (int i = 0; i < CAND_N && !found; i++) begin
          if (!cd_valid[i]) begin
            cd_valid[i] = 1'b1;
            cd_owner[i] = r.owner_id;
            cd_bytes[i] = r.amount;
            cd_time[i] = r.now_ns;
            found = 1'b1;
          end
        end
        if (!found) rsp.status = STAT_FULL;
        else if (flush_due()) begin
          pick = 0;
          found = 1'b0;
          for (int i = 0; i < CAND_N; i++) begin
            if (cd_valid[i] && (!found || cd_time[i] < cd_time[pick])) begin
              pick = i;
              found = 1'b1;
            end
          end
          cd_valid[pick] = 1'b0;
          rsp.flush_request = 1'b1;
          rsp.flush_owner = cd_owner[pick];
        end
      end
      FUNC_UNREGISTER: begin
        pick = 0;
        found = 1'b0;
        for (int i = 0; i < CAND_N; i++) begin
          if (cd_valid[i] && cd_owner[i] == r.owner_id && cd_bytes[i] == r.amount &&
              (!found || cd_time[i] < cd_time[pick])) begin
            pick = i;
            found = 1'b1;
          end
        end
        if (found) cd_valid[pick] = 1'b0;
        else rsp.status = STAT_NOT_FOUND;
      end
      FUNC_SHUTDOWN: halted = 1'b1;
      default: ;
    endcase
    rsp.usage = bud_total;
    for (int i = 0; i < CAND_N; i++) rsp.candidate_count += 5'(cd_valid[i]);
    return rsp;
  endfunction

  // Request driver: holds a request until accepted, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_rsps.push_back(budget_step(in_req));
        if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_req <= pending_reqs[0];
        pending_reqs.delete(0);
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: each result is checked against the oldest expectation.
  always @(posedge clk) begin
    wbft_rsp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %p", out_rsp);
      end else begin
        exp_rsp = expected_rsps[0];
        expected_rsps.delete(0);
        if (out_rsp !== exp_rsp) begin
          fails++;
          if (fails <= 10) begin
            $display("mismatch: status %0d/%0d usage %0d/%0d flush %0b/%0b", exp_rsp.status,
                     out_rsp.status, exp_rsp.usage, out_rsp.usage, exp_rsp.flush_request,
                     out_rsp.flush_request);
            $display("  owner %0d/%0d count %0d/%0d (expected/actual)", exp_rsp.flush_owner,
                     out_rsp.flush_owner, exp_rsp.candidate_count, out_rsp.candidate_count);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [4:0] addr, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_LIMIT: bud_limit = data[39:0];
      ADDR_WINDOW: prune_age = data[47:0];
      default: fill_deadline = data[47:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic wbft_req_t mk_req(logic [2:0] f, logic [7:0] o, logic [39:0] a,
                                       logic [47:0] t);
    wbft_req_t r;
    r.func = f;
    r.owner_id = o;
    r.amount = a;
    r.now_ns = t;
    return r;
  endfunction

  // Random phase: mostly coherent traffic with recent candidate pairs reused.
  task automatic random_phase(logic [39:0] lim, int count);
    logic [47:0] clock_ns;
    logic [39:0] amt;
    logic [7:0] own;
    logic [2:0] f;
    wbft_req_t known[$];
    int pick;
    clock_ns = 48'd1000;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) f = FUNC_RESERVE;
      else if (pick < 55) f = FUNC_FREE;
      else if (pick < 75) f = FUNC_REGISTER;
      else if (pick < 95) f = FUNC_UNREGISTER;
      else f = 3'($urandom_range(5, 7));
      case ($urandom_range(0, 31))
        0: clock_ns = 48'({$urandom, $urandom});
        1: clock_ns = clock_ns - 48'($urandom_range(0, 5000));
        default: clock_ns = clock_ns + 48'($urandom_range(0, 3000));
      endcase
      amt = ($urandom_range(0, 15) == 0) ? 40'({$urandom, $urandom})
            : 40'({$urandom, $urandom} % (64'(lim) / 4 + 1));
      own = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if (f == FUNC_UNREGISTER && known.size() > 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, known.size() - 1);
        own = known[pick].owner_id;
        amt = known[pick].amount;
      end
      if (f == FUNC_REGISTER) begin
        known.push_back(mk_req(f, own, amt, clock_ns));
        if (known.size() > 32) known.delete(0);
      end
      pending_reqs.push_back(mk_req(f, own, amt, clock_ns));
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration.
    pending_reqs.push_back(mk_req(FUNC_RESERVE, 8'd1, 40'd0, 48'd100));
    pending_reqs.push_back(mk_req(FUNC_RESERVE, 8'd1, 40'hFF_FFFF_FFFF, 48'd200));
    pending_reqs.push_back(mk_req(FUNC_RESERVE, 8'd1, LIMIT_RST, 48'd300));
    pending_reqs.push_back(mk_req(FUNC_REGISTER, 8'd255, 40'd1, 48'd400));
    pending_reqs.push_back(mk_req(FUNC_FREE, 8'd0, 40'hFF_FFFF_FFFF, 48'd500));
    for (int i = 0; i <= CAND_N; i++)
      pending_reqs.push_back(mk_req(FUNC_REGISTER, 8'(i), 40'(i), 48'(1000 - i)));
    pending_reqs.push_back(mk_req(FUNC_UNREGISTER, 8'd3, 40'd3, 48'd2000));
    pending_reqs.push_back(mk_req(FUNC_UNREGISTER, 8'd3, 40'd4, 48'd2001));
    pending_reqs.push_back(mk_req(3'd7, 8'd0, 40'd0, 48'hFFFF_FFFF_FFFF));
    wait_idle();

    write_reg(ADDR_LIMIT, 64'd1048576);
    write_reg(ADDR_WINDOW, 64'd1000000);
    random_phase(40'd1048576, PHASE_ITEMS);

    write_reg(ADDR_LIMIT, 64'hFF_FFFF_FFFF);
    write_reg(ADDR_WINDOW, 64'hFFFF_FFFF_FFFF);
    write_reg(ADDR_FTL, 64'hFFFF_FFFF_FFFF);
    random_phase(40'hFF_FFFF_FFFF, PHASE_ITEMS);

    write_reg(ADDR_LIMIT, 64'd0);
    write_reg(ADDR_WINDOW, 64'd1);
    write_reg(ADDR_FTL, 64'd1);
    random_phase(40'd0, PHASE_ITEMS);

    // Last part runs without idle bursts, then sends a shutdown followed by a reserve, a free and a register.
    write_reg(ADDR_LIMIT, 64'd1000000);
    write_reg(ADDR_WINDOW, 64'd5000);
    write_reg(ADDR_FTL, 64'd1000000000);
    idling_on = 1'b0;
    random_phase(40'd1000000, PHASE_ITEMS);
    pending_reqs.push_back(mk_req(FUNC_SHUTDOWN, 8'd0, 40'd0, 48'd10));
    pending_reqs.push_back(mk_req(FUNC_RESERVE, 8'd0, 40'd5, 48'd20));
    pending_reqs.push_back(mk_req(FUNC_FREE, 8'd0, 40'd5, 48'd30));
    pending_reqs.push_back(mk_req(FUNC_REGISTER, 8'd9, 40'd5, 48'd40));
    wait_idle();

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
